// ===== rtl/code_lock_alarm_controller_defines.svh =====
// assertion macros shared by the rtl
`ifndef CODE_LOCK_ALARM_CONTROLLER_DEFINES_SVH
`define CODE_LOCK_ALARM_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define CLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/cla_pkg.sv =====
package cla_pkg;

    // event codes of a result
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_STEP  = 3'd1;
    localparam logic [2:0] EV_RIGHT = 3'd2;
    localparam logic [2:0] EV_WRONG = 3'd3;
    localparam logic [2:0] EV_DONE  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_CODE_FIRST    = 3'd0;
    localparam logic [2:0] REG_CODE_SECOND   = 3'd1;
    localparam logic [2:0] REG_CODE_THIRD    = 3'd2;
    localparam logic [2:0] REG_GUARD_TICKS   = 3'd3;
    localparam logic [2:0] REG_ENTRY_TIMEOUT = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [7:0]  GUARD_TICKS_RST   = 8'd2;
    localparam logic [15:0] ENTRY_TIMEOUT_RST = 16'd10;
    localparam logic [3:0]  MAX_DIGIT         = 4'd9;

    // code positions
    localparam logic [1:0] POS_FIRST  = 2'd1;
    localparam logic [1:0] POS_SECOND = 2'd2;
    localparam logic [1:0] POS_THIRD  = 2'd3;

    typedef struct packed {
        logic button_edge;
        logic presence;
    } t_in_item;

    typedef struct packed {
        logic       armed;
        logic       siren_on;
        logic [1:0] position;
        logic       entered_valid;
        logic [3:0] entered_value;
        logic [2:0] event_res;
    } t_out_item;

endpackage

// ===== rtl/code_lock_alarm_controller.sv =====
// code_lock_alarm_controller
// three-digit code lock that arms and disarms an intruder alarm, one tick per transaction
// input channel: i_in_valid / o_in_stall carry one tick (button edge, presence level);
//   a transaction completes at a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carry one result per tick: armed, siren,
//   code position, entered digit and the event of that tick
// config port: i_cfg_we writes i_cfg_data into register i_cfg_index (0..4), one per
//   cycle, no read-back; indexes above 4 are dropped; write only while the block is idle
// latency: a tick taken at edge k shows its result on the output after edge k+1
//   (input register, then one pass of counter and compare logic into the result register)
// throughput: one tick per cycle; the next tick is taken while a result still waits,
//   since the input register and the result register form two separate stages
// stall: while the result register is held by i_out_stall, the pending tick waits in the
//   input register and o_in_stall rises only once that register is occupied too
// reset (i_rst_n low, synchronous): both stages empty, lock at position 1, no digit,
//   disarmed, siren off, guard 2 ticks, entry timeout 10 ticks, code digits 0
module code_lock_alarm_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cla_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cla_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [cla_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cla_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // configuration registers
    logic [3:0]  r_code_first;
    logic [3:0]  r_code_second;
    logic [3:0]  r_code_third;
    logic [7:0]  r_guard_ticks;
    logic [15:0] r_entry_timeout;

    // lock state
    logic        r_press_pending, n_press_pending;
    logic [7:0]  r_guard_count,   n_guard_count;
    logic [15:0] r_idle_count,    n_idle_count;
    logic [1:0]  r_digit_pos,     n_digit_pos;
    logic        r_have_value,    n_have_value;
    logic [3:0]  r_digit_value,   n_digit_value;
    logic        r_is_armed,      n_is_armed;
    logic        r_siren,         n_siren;
    logic [2:0]  n_event;

    // pipeline stages
    logic                r_in_valid;
    cla_pkg::t_in_item   r_in_item;
    logic                r_out_valid;
    cla_pkg::t_out_item  r_out_item;

    logic w_advance;
    logic w_fire;

    // result decodes for the checks
    logic w_res_step;
    logic w_res_done;
    logic w_res_quiet_first;

    // result register frees up when empty or being drained
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_first    <= 4'd0;
            r_code_second   <= 4'd0;
            r_code_third    <= 4'd0;
            r_guard_ticks   <= cla_pkg::GUARD_TICKS_RST;
            r_entry_timeout <= cla_pkg::ENTRY_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cla_pkg::REG_CODE_FIRST:    r_code_first    <= i_cfg_data[3:0];
                cla_pkg::REG_CODE_SECOND:   r_code_second   <= i_cfg_data[3:0];
                cla_pkg::REG_CODE_THIRD:    r_code_third    <= i_cfg_data[3:0];
                cla_pkg::REG_GUARD_TICKS:   r_guard_ticks   <= i_cfg_data[7:0];
                cla_pkg::REG_ENTRY_TIMEOUT: r_entry_timeout <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // one tick of debounce, digit entry and alarm logic
    always_comb begin
        logic       pend;
        logic [3:0] expected;
        logic       done;

        n_press_pending = r_press_pending;
        n_guard_count   = r_guard_count;
        n_idle_count    = r_idle_count;
        n_digit_pos     = r_digit_pos;
        n_have_value    = r_have_value;
        n_digit_value   = r_digit_value;
        n_is_armed      = r_is_armed;
        n_siren         = r_siren;
        n_event         = cla_pkg::EV_NONE;
        done            = 1'b0;

        // debouncer: an edge is a press only once the guard has run out
        pend = r_press_pending;
        if (r_in_item.button_edge) begin
            if (r_guard_count == 8'd0) begin
                pend = 1'b1;
            end
            n_guard_count = r_guard_ticks;
        end else if (r_guard_count != 8'd0) begin
            n_guard_count = r_guard_count - 8'd1;
        end
        n_press_pending = pend;

        // code digit at the current position
        case (r_digit_pos)
            cla_pkg::POS_FIRST:  expected = r_code_first;
            cla_pkg::POS_SECOND: expected = r_code_second;
            default:             expected = r_code_third;
        endcase

        // digit entry: press steps the digit, timeout judges it
        if (pend) begin
            n_press_pending = 1'b0;
            if (!r_have_value) begin
                n_digit_value = 4'd0;
                n_have_value  = 1'b1;
            end else if (r_digit_value < cla_pkg::MAX_DIGIT) begin
                n_digit_value = r_digit_value + 4'd1;
            end else begin
                n_digit_value = 4'd0;
            end
            n_idle_count = r_entry_timeout;
            n_event      = cla_pkg::EV_STEP;
        end else if (r_have_value && (r_idle_count == 16'd0)) begin
            if (r_digit_value == expected) begin
                if (r_digit_pos == cla_pkg::POS_THIRD) begin
                    n_digit_pos = cla_pkg::POS_FIRST;
                    done        = 1'b1;
                    n_event     = cla_pkg::EV_DONE;
                end else begin
                    n_digit_pos = r_digit_pos + 2'd1;
                    n_event     = cla_pkg::EV_RIGHT;
                end
            end else begin
                n_digit_pos = cla_pkg::POS_FIRST;
                n_event     = cla_pkg::EV_WRONG;
            end
            n_have_value    = 1'b0;
            n_digit_value   = 4'd0;
            n_press_pending = 1'b0;
        end else if (r_idle_count != 16'd0) begin
            n_idle_count = r_idle_count - 16'd1;
        end

        // alarm: a completed code toggles arming and silences the siren; presence while armed sets the siren
        if (done) begin
            n_is_armed = !r_is_armed;
            n_siren    = 1'b0;
        end else if (r_is_armed && r_in_item.presence) begin
            n_siren = 1'b1;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // lock state, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_pending <= 1'b0;
            r_guard_count   <= 8'd0;
            r_idle_count    <= cla_pkg::ENTRY_TIMEOUT_RST;
            r_digit_pos     <= cla_pkg::POS_FIRST;
            r_have_value    <= 1'b0;
            r_digit_value   <= 4'd0;
            r_is_armed      <= 1'b0;
            r_siren         <= 1'b0;
        end else if (w_fire) begin
            r_press_pending <= n_press_pending;
            r_guard_count   <= n_guard_count;
            r_idle_count    <= n_idle_count;
            r_digit_pos     <= n_digit_pos;
            r_have_value    <= n_have_value;
            r_digit_value   <= n_digit_value;
            r_is_armed      <= n_is_armed;
            r_siren         <= n_siren;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item.armed         <= n_is_armed;
            r_out_item.siren_on      <= n_siren;
            r_out_item.position      <= n_digit_pos;
            r_out_item.entered_valid <= n_have_value;
            r_out_item.entered_value <= n_have_value ? n_digit_value : 4'd0;
            r_out_item.event_res     <= n_event;
        end
    end

    // checks
    `include "code_lock_alarm_controller_defines.svh"

    assign w_res_step = o_out_valid && (o_out_item.event_res == cla_pkg::EV_STEP);
    assign w_res_done = o_out_valid && (o_out_item.event_res == cla_pkg::EV_DONE);
    assign w_res_quiet_first = (o_out_item.position == cla_pkg::POS_FIRST) &&
                               !o_out_item.siren_on;

    `CLA_ASSERT_NOW(a_pos_never_zero, i_clk, i_rst_n, 1'b1, r_digit_pos != 2'd0)
    `CLA_ASSERT_NOW(a_step_has_digit, i_clk, i_rst_n, w_res_step, o_out_item.entered_valid)
    `CLA_ASSERT_NOW(a_done_back_to_first, i_clk, i_rst_n, w_res_done, w_res_quiet_first)
    `CLA_ASSERT_NEXT(a_held_result_kept, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

endmodule
